@@ rtl/core/mpeg2_video_header_parser_top_defines.svh @@
// assertion macros for the header parser
`ifndef MPEG2_VIDEO_HEADER_PARSER_TOP_DEFINES_SVH
`define MPEG2_VIDEO_HEADER_PARSER_TOP_DEFINES_SVH

`ifndef SYNTH
`define MVHP_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("check failed: cond");
`define MVHP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("check failed: ante implies cons");
`define MVHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("check failed: ante then cons");
`else
`define MVHP_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define MVHP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MVHP_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/core/mvhp_pkg.sv @@
`default_nettype none
package mvhp_pkg;

    localparam int MATRIX_ENTRIES = 64;
    localparam int M1 = MATRIX_ENTRIES + 1;

    typedef logic [3:0] hdr_t;

    localparam hdr_t HDR_SEQ     = 4'd0;
    localparam hdr_t HDR_GOP     = 4'd1;
    localparam hdr_t HDR_PIC     = 4'd2;
    localparam hdr_t HDR_SEQX    = 4'd3;
    localparam hdr_t HDR_SDX     = 4'd4;
    localparam hdr_t HDR_QMX     = 4'd5;
    localparam hdr_t HDR_CPX     = 4'd6;
    localparam hdr_t HDR_SSX     = 4'd7;
    localparam hdr_t HDR_PDX     = 4'd8;
    localparam hdr_t HDR_PCX     = 4'd9;
    localparam hdr_t HDR_PSX     = 4'd10;
    localparam hdr_t HDR_PTX     = 4'd11;
    localparam hdr_t HDR_EXT_ID  = 4'd12;
    localparam hdr_t HDR_AWAIT   = 4'd13;
    localparam hdr_t HDR_IDLE    = 4'd15;

    localparam logic [3:0] EXTID_SEQ  = 4'd1;
    localparam logic [3:0] EXTID_SDX  = 4'd2;
    localparam logic [3:0] EXTID_QMX  = 4'd3;
    localparam logic [3:0] EXTID_CPX  = 4'd4;
    localparam logic [3:0] EXTID_SSX  = 4'd5;
    localparam logic [3:0] EXTID_PDX  = 4'd7;
    localparam logic [3:0] EXTID_PCX  = 4'd8;
    localparam logic [3:0] EXTID_PSX  = 4'd9;
    localparam logic [3:0] EXTID_PTX  = 4'd10;

    localparam logic [7:0] SC_PIC    = 8'h00;
    localparam logic [7:0] SC_SEQ    = 8'hB3;
    localparam logic [7:0] SC_EXT    = 8'hB5;
    localparam logic [7:0] SC_GOP    = 8'hB8;
    localparam logic [7:0] SC_PREFIX = 8'h01;

    localparam logic [2:0] CT_P = 3'd2;
    localparam logic [2:0] CT_B = 3'd3;
    localparam logic [1:0] SCAL_SPATIAL  = 2'd1;
    localparam logic [1:0] SCAL_TEMPORAL = 2'd3;

    localparam logic [6:0] NO_FIELD = 7'h7F;

    typedef struct packed {
        logic [4:0] w;
        logic [6:0] id;
        logic       last;
        logic [5:0] idx;
    } fdesc_t;

    typedef struct packed {
        logic [4:0]  w;
        logic [6:0]  id;
        logic [5:0]  idx;
        logic [24:0] value;
        logic [8:0]  nx;
        logic        is_end;
    } dec_t;

    typedef struct packed {
        hdr_t        kind;
        logic [6:0]  id;
        logic [5:0]  idx;
        logic [24:0] value;
        logic        done;
    } result_t;

    function automatic fdesc_t tf(input logic [4:0] w, input logic [6:0] id,
                                  input logic last);
        fdesc_t f;
        f.w    = w;
        f.id   = id;
        f.last = last;
        f.idx  = 6'd0;
        return f;
    endfunction

    // fixed part of each header syntax
    function automatic fdesc_t tab_lookup(input hdr_t kind, input logic [8:0] step);
        fdesc_t d;
        d = '0;
        case (kind)
            HDR_SEQ: begin
                case (step)
                    9'd0: d = tf(5'd12, 7'd0, 1'b0);
                    9'd1: d = tf(5'd12, 7'd1, 1'b0);
                    9'd2: d = tf(5'd4, 7'd2, 1'b0);
                    9'd3: d = tf(5'd4, 7'd3, 1'b0);
                    9'd4: d = tf(5'd18, 7'd4, 1'b0);
                    9'd5: d = tf(5'd1, NO_FIELD, 1'b0);
                    9'd6: d = tf(5'd10, 7'd5, 1'b0);
                    9'd7: d = tf(5'd1, 7'd6, 1'b0);
                    9'd8: d = tf(5'd1, 7'd7, 1'b0);
                    default: d = '0;
                endcase
            end
            HDR_GOP: begin
                case (step)
                    9'd0: d = tf(5'd25, 7'd0, 1'b0);
                    9'd1: d = tf(5'd1, 7'd1, 1'b0);
                    9'd2: d = tf(5'd1, 7'd2, 1'b1);
                    default: d = '0;
                endcase
            end
            HDR_PIC: begin
                case (step)
                    9'd0: d = tf(5'd10, 7'd0, 1'b0);
                    9'd1: d = tf(5'd3, 7'd1, 1'b0);
                    9'd2: d = tf(5'd16, 7'd2, 1'b0);
                    9'd3: d = tf(5'd1, 7'd3, 1'b0);
                    9'd4: d = tf(5'd3, 7'd4, 1'b0);
                    9'd5: d = tf(5'd1, 7'd5, 1'b0);
                    9'd6: d = tf(5'd3, 7'd6, 1'b0);
                    9'd7: d = tf(5'd1, 7'd7, 1'b0);
                    9'd8: d = tf(5'd8, NO_FIELD, 1'b0);
                    default: d = '0;
                endcase
            end
            HDR_SEQX: begin
                case (step)
                    9'd0:  d = tf(5'd8, 7'd0, 1'b0);
                    9'd1:  d = tf(5'd1, 7'd1, 1'b0);
                    9'd2:  d = tf(5'd2, 7'd2, 1'b0);
                    9'd3:  d = tf(5'd2, 7'd3, 1'b0);
                    9'd4:  d = tf(5'd2, 7'd4, 1'b0);
                    9'd5:  d = tf(5'd12, 7'd5, 1'b0);
                    9'd6:  d = tf(5'd1, NO_FIELD, 1'b0);
                    9'd7:  d = tf(5'd8, 7'd6, 1'b0);
                    9'd8:  d = tf(5'd1, 7'd7, 1'b0);
                    9'd9:  d = tf(5'd2, 7'd8, 1'b0);
                    9'd10: d = tf(5'd5, 7'd9, 1'b1);
                    default: d = '0;
                endcase
            end
            HDR_SDX: begin
                case (step)
                    9'd0: d = tf(5'd3, 7'd0, 1'b0);
                    9'd1: d = tf(5'd1, 7'd1, 1'b0);
                    9'd2: d = tf(5'd8, 7'd2, 1'b0);
                    9'd3: d = tf(5'd8, 7'd3, 1'b0);
                    9'd4: d = tf(5'd8, 7'd4, 1'b0);
                    9'd5: d = tf(5'd14, 7'd5, 1'b0);
                    9'd6: d = tf(5'd1, NO_FIELD, 1'b0);
                    9'd7: d = tf(5'd14, 7'd6, 1'b1);
                    default: d = '0;
                endcase
            end
            HDR_CPX: begin
                case (step)
                    9'd0: d = tf(5'd1, 7'd0, 1'b0);
                    9'd1: d = tf(5'd8, 7'd1, 1'b0);
                    9'd2: d = tf(5'd1, 7'd2, 1'b0);
                    9'd3: d = tf(5'd8, NO_FIELD, 1'b0);
                    9'd4: d = tf(5'd20, 7'd3, 1'b0);
                    9'd5: d = tf(5'd1, NO_FIELD, 1'b0);
                    9'd6: d = tf(5'd22, 7'd4, 1'b0);
                    9'd7: d = tf(5'd1, NO_FIELD, 1'b0);
                    9'd8: d = tf(5'd22, 7'd5, 1'b1);
                    default: d = '0;
                endcase
            end
            HDR_SSX: begin
                case (step)
                    9'd0:  d = tf(5'd2, 7'd0, 1'b0);
                    9'd1:  d = tf(5'd4, 7'd1, 1'b0);
                    9'd2:  d = tf(5'd14, 7'd2, 1'b0);
                    9'd3:  d = tf(5'd1, NO_FIELD, 1'b0);
                    9'd4:  d = tf(5'd14, 7'd3, 1'b0);
                    9'd5:  d = tf(5'd5, 7'd4, 1'b0);
                    9'd6:  d = tf(5'd5, 7'd5, 1'b0);
                    9'd7:  d = tf(5'd5, 7'd6, 1'b0);
                    9'd8:  d = tf(5'd5, 7'd7, 1'b1);
                    9'd9:  d = tf(5'd1, 7'd8, 1'b0);
                    9'd10: d = tf(5'd1, 7'd9, 1'b0);
                    9'd11: d = tf(5'd3, 7'd10, 1'b0);
                    9'd12: d = tf(5'd3, 7'd11, 1'b1);
                    default: d = '0;
                endcase
            end
            HDR_PCX: begin
                if (step < 9'd4) begin
                    d = tf(5'd4, step[6:0], 1'b0);
                end else if (step < 9'd6) begin
                    d = tf(5'd2, step[6:0], 1'b0);
                end else if (step < 9'd17) begin
                    d = tf(5'd1, step[6:0], 1'b0);
                end else begin
                    case (step)
                        9'd17: d = tf(5'd3, 7'd17, 1'b0);
                        9'd18: d = tf(5'd1, 7'd18, 1'b0);
                        9'd19: d = tf(5'd7, 7'd19, 1'b0);
                        9'd20: d = tf(5'd8, 7'd20, 1'b1);
                        default: d = '0;
                    endcase
                end
            end
            HDR_PSX: begin
                case (step)
                    9'd0: d = tf(5'd10, 7'd0, 1'b0);
                    9'd1: d = tf(5'd1, NO_FIELD, 1'b0);
                    9'd2: d = tf(5'd15, 7'd1, 1'b0);
                    9'd3: d = tf(5'd1, NO_FIELD, 1'b0);
                    9'd4: d = tf(5'd15, 7'd2, 1'b0);
                    9'd5: d = tf(5'd2, 7'd3, 1'b0);
                    9'd6: d = tf(5'd1, 7'd4, 1'b0);
                    9'd7: d = tf(5'd1, 7'd5, 1'b1);
                    default: d = '0;
                endcase
            end
            HDR_PTX: begin
                case (step)
                    9'd0: d = tf(5'd2, 7'd0, 1'b0);
                    9'd1: d = tf(5'd10, 7'd1, 1'b0);
                    9'd2: d = tf(5'd1, NO_FIELD, 1'b0);
                    9'd3: d = tf(5'd10, 7'd2, 1'b1);
                    default: d = '0;
                endcase
            end
            default: d = '0;
        endcase
        return d;
    endfunction

    function automatic hdr_t ext_kind(input logic [3:0] ext_id);
        hdr_t k;
        case (ext_id)
            EXTID_SEQ: k = HDR_SEQX;
            EXTID_SDX: k = HDR_SDX;
            EXTID_QMX: k = HDR_QMX;
            EXTID_CPX: k = HDR_CPX;
            EXTID_SSX: k = HDR_SSX;
            EXTID_PDX: k = HDR_PDX;
            EXTID_PCX: k = HDR_PCX;
            EXTID_PSX: k = HDR_PSX;
            EXTID_PTX: k = HDR_PTX;
            default:   k = HDR_IDLE;
        endcase
        return k;
    endfunction

    // flags: bit0 progressive seq, bit1 rff, bit2 tff, bits 4:3 picture structure
    function automatic logic [1:0] centre_offsets(input logic [4:0] flags);
        logic [1:0] n;
        if (flags[0]) begin
            n = flags[1] ? (flags[2] ? 2'd3 : 2'd2) : 2'd1;
        end else if (flags[4:3] != 2'd3) begin
            n = 2'd1;
        end else begin
            n = flags[1] ? 2'd3 : 2'd2;
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/mvhp_field_dec.sv @@
`default_nettype none
module mvhp_field_dec (
    input  mvhp_pkg::hdr_t  kind,
    input  logic [8:0]      step,
    input  logic [5:0]      fill,
    input  logic [31:0]     reservoir,
    input  logic [2:0]      coding_type,
    input  logic [1:0]      scal_mode,
    input  logic [1:0]      offset_count,
    output mvhp_pkg::dec_t  dec
);
    import mvhp_pkg::*;

    localparam logic [8:0] SEQ_MAT = 9'd9;
    localparam logic [8:0] SEQ_NI  = 9'(9 + MATRIX_ENTRIES);
    localparam logic [8:0] SEQ_END = 9'(9 + 2 * MATRIX_ENTRIES);
    localparam logic [8:0] QM_B1   = 9'(M1);
    localparam logic [8:0] QM_B2   = 9'(2 * M1);
    localparam logic [8:0] QM_B3   = 9'(3 * M1);
    localparam logic [8:0] QM_B4   = 9'(4 * M1);

    fdesc_t      d;
    logic [8:0]  r;
    logic [8:0]  r2;
    logic [2:0]  blk;
    logic [5:0]  sh;
    logic [31:0] shifted;
    logic [31:0] mask;
    logic [31:0] vfull;
    logic [24:0] v;
    logic [8:0]  nx;
    logic        endf;
    logic [6:0]  pd_next;

    // field descriptor for this step
    always_comb begin
        d   = '0;
        r   = '0;
        r2  = '0;
        blk = 3'd4;
        case (kind)
            HDR_SEQ: begin
                if (step >= SEQ_MAT) begin
                    r  = step - SEQ_MAT;
                    r2 = r - QM_B1;
                    if (r < 9'(MATRIX_ENTRIES)) begin
                        d     = tf(5'd8, 7'd8, 1'b0);
                        d.idx = r[5:0];
                    end else if (r == 9'(MATRIX_ENTRIES)) begin
                        d = tf(5'd1, 7'd9, 1'b0);
                    end else if (r < 9'(2 * MATRIX_ENTRIES + 1)) begin
                        d     = tf(5'd8, 7'd10, 1'b0);
                        d.idx = r2[5:0];
                    end
                end else begin
                    d = tab_lookup(kind, step);
                end
            end
            HDR_QMX: begin
                if (step < QM_B1) begin
                    blk = 3'd0;
                    r   = step;
                end else if (step < QM_B2) begin
                    blk = 3'd1;
                    r   = step - QM_B1;
                end else if (step < QM_B3) begin
                    blk = 3'd2;
                    r   = step - QM_B2;
                end else if (step < QM_B4) begin
                    blk = 3'd3;
                    r   = step - QM_B3;
                end
                r2 = r - 9'd1;
                if (!blk[2]) begin
                    if (r == 9'd0) begin
                        d = tf(5'd1, {4'd0, blk[1:0], 1'b0}, 1'b0);
                    end else begin
                        d     = tf(5'd8, {4'd0, blk[1:0], 1'b1}, 1'b0);
                        d.idx = r2[5:0];
                    end
                end
            end
            HDR_PDX: begin
                if (step[8:2] < 7'd3) begin
                    case (step[1:0])
                        2'd0:    d = tf(5'd14, 7'd0, 1'b0);
                        2'd2:    d = tf(5'd14, 7'd1, 1'b0);
                        default: d = tf(5'd1, NO_FIELD, 1'b0);
                    endcase
                    d.idx = {4'd0, step[3:2]};
                end
            end
            default: d = tab_lookup(kind, step);
        endcase
    end

    // field value from the top of the reservoir
    always_comb begin
        sh      = fill - {1'b0, d.w};
        shifted = reservoir >> sh;
        mask    = (32'd1 << d.w) - 32'd1;
        vfull   = shifted & mask;
        v       = vfull[24:0];
    end

    // next syntax step
    always_comb begin
        nx      = step + 9'd1;
        endf    = d.last;
        pd_next = step[8:2] + 7'd1;
        case (kind)
            HDR_SEQ: begin
                if (step == 9'd8 && v == '0) begin
                    nx = SEQ_NI;
                end else if (step == SEQ_NI && v == '0) begin
                    endf = 1'b1;
                end else if (step >= SEQ_END) begin
                    endf = 1'b1;
                end
            end
            HDR_PIC: begin
                case (step)
                    9'd2: nx = (coding_type == CT_P || coding_type == CT_B) ? 9'd3 : 9'd7;
                    9'd4: nx = (coding_type == CT_B) ? 9'd5 : 9'd7;
                    9'd7: begin
                        if (v == '0) begin
                            endf = 1'b1;
                        end
                    end
                    9'd8: nx = 9'd7;
                    default: ;
                endcase
            end
            HDR_SDX: begin
                if (step == 9'd1 && v == '0) begin
                    nx = 9'd5;
                end
            end
            HDR_QMX: begin
                if (r == 9'd0 && v == '0) begin
                    case (blk[1:0])
                        2'd0:    nx = QM_B1;
                        2'd1:    nx = QM_B2;
                        2'd2:    nx = QM_B3;
                        default: nx = QM_B4;
                    endcase
                end
                if (nx >= QM_B4) begin
                    endf = 1'b1;
                end
            end
            HDR_SSX: begin
                if (step == 9'd1) begin
                    if (scal_mode == SCAL_SPATIAL) begin
                        nx = 9'd2;
                    end else if (scal_mode == SCAL_TEMPORAL) begin
                        nx = 9'd9;
                    end else begin
                        endf = 1'b1;
                    end
                end else if (step == 9'd9 && v == '0) begin
                    nx = 9'd11;
                end
            end
            HDR_PDX: begin
                if (step[1:0] == 2'd2 && pd_next >= {5'd0, offset_count}) begin
                    endf = 1'b1;
                end
            end
            HDR_PCX: begin
                if (step == 9'd15 && v == '0) begin
                    endf = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign dec.w      = d.w;
    assign dec.id     = d.id;
    assign dec.idx    = d.idx;
    assign dec.value  = v;
    assign dec.nx     = nx;
    assign dec.is_end = endf;

endmodule
`default_nettype wire

@@ rtl/core/mvhp_out_reg.sv @@
`default_nettype none
module mvhp_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  mvhp_pkg::result_t din,
    output logic              out_free,
    output logic              m_valid,
    input  logic              m_ready,
    output mvhp_pkg::result_t dout
);
    import mvhp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    // free when empty or the held word leaves this cycle
    assign out_free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= din;
        end
    end

    assign m_valid = valid_reg;
    assign dout    = data_reg;

endmodule
`default_nettype wire

@@ rtl/core/mpeg2_video_header_parser_top.sv @@
// channel   dir  ports                                      word
// --------  ---  -----------------------------------------  ---------------------------------
// stream    in   s_valid s_ready s_data_byte                one stream byte
// fields    out  m_valid m_ready m_header_kind m_field_id   one header field, id/value pair
//                m_entry_index m_field_value m_header_done
//
// one field is taken from the bit reservoir per cycle while its bits are held and the
// output is free; a byte is taken per cycle while the fields are 8 bits or wider
// a byte goes in alongside a field step when the reservoir holds at most 24 bits after
// it and the byte does not close a start code prefix
// reset is synchronous, active low, and leaves the parser idle hunting for a start code
// m_ready low holds back only the field steps that produce a word
`default_nettype none
`include "mpeg2_video_header_parser_top_defines.svh"
module mpeg2_video_header_parser_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_header_kind,
    output logic [6:0]  m_field_id,
    output logic [5:0]  m_entry_index,
    output logic [24:0] m_field_value,
    output logic        m_header_done
);
    import mvhp_pkg::*;

    // parser state
    logic [1:0]  zero_run_reg, zero_run_next;
    hdr_t        cur_hdr_reg, cur_hdr_next;
    logic [8:0]  step_reg, step_next;
    logic [31:0] res_reg, res_next;
    logic [5:0]  fill_reg, fill_next;
    logic [2:0]  coding_type_reg, coding_type_next;
    logic [1:0]  scal_mode_reg, scal_mode_next;
    logic [4:0]  flags_reg, flags_next;
    logic [1:0]  offcnt_reg, offcnt_next;

    dec_t        dec;
    result_t     res_word;
    result_t     out_word;
    logic        out_free;
    logic        is_ext;
    logic        in_hdr;
    logic        pending;
    logic        emit;
    logic        step_go;
    logic        prefix_hit;
    logic        accept;
    logic [5:0]  ext_shift;
    logic [31:0] ext_bits;
    hdr_t        ext_k;

    mvhp_field_dec u_dec (
        .kind         (cur_hdr_reg),
        .step         (step_reg),
        .fill         (fill_reg),
        .reservoir    (res_reg),
        .coding_type  (coding_type_reg),
        .scal_mode    (scal_mode_reg),
        .offset_count (offcnt_reg),
        .dec          (dec)
    );

    // what can be done from the bits already held
    assign is_ext     = (cur_hdr_reg == HDR_EXT_ID);
    assign in_hdr     = (cur_hdr_reg < HDR_EXT_ID);
    assign pending    = (is_ext && fill_reg >= 6'd4) ||
                        (in_hdr && (dec.w == 5'd0 || fill_reg >= {1'b0, dec.w}));
    assign emit       = in_hdr && dec.w != 5'd0 && dec.id != NO_FIELD;
    assign step_go    = pending && (!emit || out_free);
    assign prefix_hit = (s_data_byte == SC_PREFIX) && (zero_run_reg == 2'd2);

    assign ext_shift  = fill_reg - 6'd4;
    assign ext_bits   = res_reg >> ext_shift;
    assign ext_k      = ext_kind(ext_bits[3:0]);

    assign res_word.kind  = cur_hdr_reg;
    assign res_word.id    = dec.id;
    assign res_word.idx   = dec.idx;
    assign res_word.value = dec.value;
    assign res_word.done  = dec.is_end;

    always_comb begin
        zero_run_next    = zero_run_reg;
        cur_hdr_next     = cur_hdr_reg;
        step_next        = step_reg;
        res_next         = res_reg;
        fill_next        = fill_reg;
        coding_type_next = coding_type_reg;
        scal_mode_next   = scal_mode_reg;
        flags_next       = flags_reg;
        offcnt_next      = offcnt_reg;

        // one syntax step
        if (step_go) begin
            if (is_ext) begin
                if (ext_k == HDR_IDLE) begin
                    cur_hdr_next = HDR_IDLE;
                    fill_next    = 6'd0;
                end else begin
                    fill_next    = fill_reg - 6'd4;
                    cur_hdr_next = ext_k;
                    step_next    = 9'd0;
                    if (ext_k == HDR_PDX) begin
                        offcnt_next = centre_offsets(flags_reg);
                    end
                end
            end else if (dec.w == 5'd0) begin
                cur_hdr_next = HDR_IDLE;
                fill_next    = 6'd0;
            end else begin
                fill_next = fill_reg - {1'b0, dec.w};
                case (cur_hdr_reg)
                    HDR_PIC: begin
                        if (step_reg == 9'd1) begin
                            coding_type_next = dec.value[2:0];
                        end
                    end
                    HDR_SEQX: begin
                        if (step_reg == 9'd1) begin
                            flags_next[0] = dec.value[0];
                        end
                    end
                    HDR_SSX: begin
                        if (step_reg == 9'd0) begin
                            scal_mode_next = dec.value[1:0];
                        end
                    end
                    HDR_PCX: begin
                        // picture structure, top field first, repeat first field
                        if (step_reg == 9'd5) begin
                            flags_next[4:3] = dec.value[1:0];
                        end else if (step_reg == 9'd6) begin
                            flags_next[2] = dec.value[0];
                        end else if (step_reg == 9'd12) begin
                            flags_next[1] = dec.value[0];
                        end
                    end
                    default: ;
                endcase
                if (dec.is_end) begin
                    cur_hdr_next = HDR_IDLE;
                    fill_next    = 6'd0;
                end else begin
                    step_next = dec.nx;
                end
            end
        end

        // byte intake, ordered after the step above
        s_ready = !pending || (step_go && fill_next <= 6'd24 && !prefix_hit);
        accept  = s_valid && s_ready;

        if (accept) begin
            if (s_data_byte == 8'd0) begin
                zero_run_next = (zero_run_reg == 2'd2) ? 2'd2 : zero_run_reg + 2'd1;
            end else begin
                zero_run_next = 2'd0;
            end
            if (cur_hdr_next == HDR_AWAIT) begin
                step_next        = 9'd0;
                coding_type_next = 3'd0;
                scal_mode_next   = 2'd0;
                fill_next        = 6'd0;
                case (s_data_byte)
                    SC_SEQ:  cur_hdr_next = HDR_SEQ;
                    SC_GOP:  cur_hdr_next = HDR_GOP;
                    SC_PIC:  cur_hdr_next = HDR_PIC;
                    SC_EXT:  cur_hdr_next = HDR_EXT_ID;
                    default: cur_hdr_next = HDR_IDLE;
                endcase
            end else if (prefix_hit) begin
                cur_hdr_next = HDR_AWAIT;
                fill_next    = 6'd0;
            end else if (cur_hdr_next <= HDR_EXT_ID) begin
                res_next  = {res_reg[23:0], s_data_byte};
                fill_next = fill_next + 6'd8;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zero_run_reg    <= 2'd0;
            cur_hdr_reg     <= HDR_IDLE;
            step_reg        <= 9'd0;
            res_reg         <= 32'd0;
            fill_reg        <= 6'd0;
            coding_type_reg <= 3'd0;
            scal_mode_reg   <= 2'd0;
            flags_reg       <= 5'd0;
            offcnt_reg      <= 2'd0;
        end else begin
            zero_run_reg    <= zero_run_next;
            cur_hdr_reg     <= cur_hdr_next;
            step_reg        <= step_next;
            res_reg         <= res_next;
            fill_reg        <= fill_next;
            coding_type_reg <= coding_type_next;
            scal_mode_reg   <= scal_mode_next;
            flags_reg       <= flags_next;
            offcnt_reg      <= offcnt_next;
        end
    end

    // result word register
    mvhp_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (step_go && emit),
        .din      (res_word),
        .out_free (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .dout     (out_word)
    );

    assign m_header_kind = out_word.kind;
    assign m_field_id    = out_word.id;
    assign m_entry_index = out_word.idx;
    assign m_field_value = out_word.value;
    assign m_header_done = out_word.done;

    `MVHP_ASSERT_ALWAYS(a_fill_max, aclk, aresetn, fill_reg <= 6'd32)
    `MVHP_ASSERT_IMP(a_await_no_step, aclk, aresetn, cur_hdr_reg == HDR_AWAIT, !pending)
    `MVHP_ASSERT_NEXT(a_emit_shown, aclk, aresetn, step_go && emit, m_valid)
    `MVHP_ASSERT_IMP(a_join_steps, aclk, aresetn, s_valid && s_ready && pending, step_go)

endmodule
`default_nettype wire
